@@ design/tsc_pkg.sv @@
// shared constants, types and command codes of the tile slot cache controller
package tsc_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int FILL_W   = $clog2(SLOTS + 1);
    localparam int RES_W    = 8;
    localparam int TILE_W   = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 32;
    localparam int TAG_W    = RES_W + TILE_W;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;

    typedef enum logic [1:0] {
        K_LOOKUP   = 2'd0,
        K_ALLOCATE = 2'd1,
        K_READY    = 2'd2,
        K_TAKE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        M_FREE     = 2'd0,
        M_READING  = 2'd1,
        M_WRITING  = 2'd2,
        M_OCCUPIED = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_LOOK,
        S_CHK,
        S_EVT,
        S_EVR,
        S_RDY,
        S_REFUSE,
        S_TAKE
    } t_state;

    typedef enum logic [3:0] {
        C_NONE,
        C_INIT,
        C_LATCH,
        C_CMP_REQ,
        C_LOOK_RES,
        C_REFUSE,
        C_POP,
        C_CHK_DROP,
        C_CHK_EVT,
        C_GRANT_FREE,
        C_REFUSE_POP,
        C_EVT_CMP,
        C_EVT_RES,
        C_RDY1,
        C_RDY2,
        C_TAKE
    } t_cmd;

    typedef struct packed {
        logic  init_done;
        t_kind kind;
        logic  fill_zero;
        t_mode pop_mode;
        logic  out_free;
    } t_status;

endpackage

@@ design/tsc_datapath.sv @@
// slot state, replacement queue, tag compare bank and result register
module tsc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsc_pkg::t_cmd      i_cmd,
    output tsc_pkg::t_status   o_status,
    input  logic [1:0]         i_kind,
    input  logic [47:0]        i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [39:0]        o_data
);
    import tsc_pkg::*;

    t_mode             r_mode [SLOTS];
    logic [RES_W-1:0]  r_res  [SLOTS];
    logic [TILE_W-1:0] r_tile [SLOTS];
    logic [TAG_W-1:0]  m_tag  [SLOTS];
    logic [SLOT_W-1:0] m_fifo [SLOTS];
    logic [SLOTS-1:0]  r_reg;
    logic [SLOTS-1:0]  r_queued;
    logic [SLOTS-1:0]  r_tagv;
    logic [SLOTS-1:0]  r_match;
    logic [SLOTS-1:0]  n_match;
    logic [SLOT_W-1:0] r_head;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_init_cnt;
    logic [CNT_W-1:0]  r_loads;
    logic [SLOT_W-1:0] r_fifo_rd;
    logic [TAG_W-1:0]  r_tag_rd;
    logic              r_tag_rd_v;
    logic              r_was_wr;

    t_kind             r_kind;
    logic [RES_W-1:0]  r_q_res;
    logic [TILE_W-1:0] r_q_tile;
    logic [IDX_W-1:0]  r_q_idx;

    logic              r_ov;
    logic [OUT_W-1:0]  r_od;

    logic [RES_W-1:0]  c_res;
    logic [TILE_W-1:0] c_tile;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] idx;
    logic              idx_ok;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] n_head;
    logic [FILL_W:0]   tail_sum;
    logic [SLOT_W-1:0] tail;
    logic              out_load;
    logic [OUT_W-1:0]  n_od;

    assign s      = r_fifo_rd;
    assign idx_ok = 32'(r_q_idx) < SLOTS;
    assign idx    = SLOT_W'(r_q_idx);
    assign n_head = (r_head == SLOT_W'(SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum = (FILL_W + 1)'(r_head) + (FILL_W + 1)'(r_fill);
    assign tail   = (tail_sum >= (FILL_W + 1)'(SLOTS)) ?
                    SLOT_W'(tail_sum - (FILL_W + 1)'(SLOTS)) : SLOT_W'(tail_sum);

    always_comb begin
        if (i_cmd == C_EVT_CMP) begin
            c_res  = r_tag_rd_v ? r_tag_rd[TAG_W-1:TILE_W] : '0;
            c_tile = r_tag_rd_v ? r_tag_rd[TILE_W-1:0] : '0;
        end else begin
            c_res  = r_q_res;
            c_tile = r_q_tile;
        end
        for (int i = 0; i < SLOTS; i++) begin
            n_match[i] = r_reg[i] && (r_res[i] == c_res) && (r_tile[i] == c_tile);
        end
        hit_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        out_load = 1'b1;
        n_od     = '0;
        case (i_cmd)
            C_LOOK_RES: begin
                n_od[0]   = |r_match;
                n_od[6:1] = (|r_match) ? IDX_W'(hit_slot) : '0;
            end
            C_GRANT_FREE: begin
                n_od[0]   = 1'b1;
                n_od[6:1] = IDX_W'(s);
            end
            C_EVT_RES: begin
                n_od[0]   = 1'b1;
                n_od[6:1] = IDX_W'(s);
                n_od[7]   = |r_match;
            end
            C_RDY2:   n_od[0] = 1'b1;
            C_TAKE: begin
                n_od[0]    = 1'b1;
                n_od[39:8] = r_loads;
            end
            C_REFUSE, C_REFUSE_POP: n_od = '0;
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_INIT) begin
            m_fifo[SLOT_W'(r_init_cnt)] <= SLOT_W'(r_init_cnt);
        end else if (i_cmd == C_RDY2 && idx_ok && !r_queued[idx] &&
                     r_fill < FILL_W'(SLOTS)) begin
            m_fifo[tail] <= idx;
        end
        if (i_cmd == C_POP || i_cmd == C_CHK_DROP) begin
            r_fifo_rd <= m_fifo[r_head];
        end
        if (i_cmd == C_RDY1 && idx_ok && r_mode[idx] == M_WRITING) begin
            m_tag[idx] <= {r_q_res, r_q_tile};
        end
        if (i_cmd == C_CHK_EVT) begin
            r_tag_rd   <= m_tag[s];
            r_tag_rd_v <= r_tagv[s];
        end
        if (i_cmd == C_CMP_REQ || i_cmd == C_RDY1 || i_cmd == C_EVT_CMP) begin
            r_match <= n_match;
        end
        if (i_cmd == C_RDY1) begin
            r_was_wr <= idx_ok && r_mode[idx] == M_WRITING;
            if (idx_ok && r_mode[idx] == M_WRITING) begin
                r_res[idx]  <= r_q_res;
                r_tile[idx] <= r_q_tile;
            end
        end
        if (i_cmd == C_LATCH) begin
            r_kind   <= t_kind'(i_kind);
            r_q_res  <= i_data[7:0];
            r_q_tile <= i_data[39:8];
            r_q_idx  <= i_data[45:40];
        end
        if (out_load) begin
            r_od <= n_od;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i] <= M_FREE;
            end
            r_reg      <= '0;
            r_queued   <= '1;
            r_tagv     <= '0;
            r_head     <= '0;
            r_fill     <= FILL_W'(SLOTS);
            r_init_cnt <= '0;
            r_loads    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd)
                C_INIT: r_init_cnt <= r_init_cnt + 1'b1;
                C_LOOK_RES: begin
                    if (|r_match) begin
                        r_mode[hit_slot] <= M_READING;
                    end
                end
                C_POP: begin
                    r_head <= n_head;
                    r_fill <= r_fill - 1'b1;
                end
                C_CHK_DROP: begin
                    r_queued[s] <= 1'b0;
                    r_head      <= n_head;
                    r_fill      <= r_fill - 1'b1;
                end
                C_CHK_EVT, C_REFUSE_POP: r_queued[s] <= 1'b0;
                C_GRANT_FREE: begin
                    r_queued[s] <= 1'b0;
                    r_mode[s]   <= M_WRITING;
                end
                C_EVT_RES: begin
                    r_reg     <= r_reg & ~r_match;
                    r_mode[s] <= M_WRITING;
                end
                C_RDY1: begin
                    if (idx_ok && r_mode[idx] == M_WRITING) begin
                        r_tagv[idx] <= 1'b1;
                    end
                end
                C_RDY2: begin
                    if (idx_ok) begin
                        if (r_was_wr) begin
                            if (!(|r_match)) begin
                                r_reg[idx] <= 1'b1;
                            end
                            if (r_loads != '1) begin
                                r_loads <= r_loads + 1'b1;
                            end
                        end
                        r_mode[idx] <= M_OCCUPIED;
                        if (!r_queued[idx] && r_fill < FILL_W'(SLOTS)) begin
                            r_fill        <= r_fill + 1'b1;
                            r_queued[idx] <= 1'b1;
                        end
                    end
                end
                C_TAKE: r_loads <= '0;
                default: ;
            endcase
        end
    end

    assign o_status.init_done = (r_init_cnt == FILL_W'(SLOTS));
    assign o_status.kind      = r_kind;
    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.pop_mode  = r_mode[s];
    assign o_status.out_free  = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

@@ design/tsc_ctrl.sv @@
// sequencing state machine of the tile slot cache controller
module tsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tsc_pkg::t_status i_status,
    output tsc_pkg::t_cmd    o_cmd
);
    import tsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                if (i_status.init_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd = C_INIT;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd   = C_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.kind)
                    K_LOOKUP: begin
                        o_cmd   = C_CMP_REQ;
                        n_state = S_LOOK;
                    end
                    K_ALLOCATE: begin
                        if (i_status.fill_zero) begin
                            n_state = S_REFUSE;
                        end else begin
                            o_cmd   = C_POP;
                            n_state = S_CHK;
                        end
                    end
                    K_READY: begin
                        o_cmd   = C_RDY1;
                        n_state = S_RDY;
                    end
                    default: n_state = S_TAKE;
                endcase
            end
            S_LOOK: begin
                if (i_status.out_free) begin
                    o_cmd   = C_LOOK_RES;
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                case (i_status.pop_mode)
                    M_FREE: begin
                        if (i_status.out_free) begin
                            o_cmd   = C_GRANT_FREE;
                            n_state = S_IDLE;
                        end
                    end
                    M_OCCUPIED: begin
                        o_cmd   = C_CHK_EVT;
                        n_state = S_EVT;
                    end
                    default: begin
                        if (!i_status.fill_zero) begin
                            o_cmd = C_CHK_DROP;
                        end else if (i_status.out_free) begin
                            o_cmd   = C_REFUSE_POP;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_EVT: begin
                o_cmd   = C_EVT_CMP;
                n_state = S_EVR;
            end
            S_EVR: begin
                if (i_status.out_free) begin
                    o_cmd   = C_EVT_RES;
                    n_state = S_IDLE;
                end
            end
            S_RDY: begin
                if (i_status.out_free) begin
                    o_cmd   = C_RDY2;
                    n_state = S_IDLE;
                end
            end
            S_REFUSE: begin
                if (i_status.out_free) begin
                    o_cmd   = C_REFUSE;
                    n_state = S_IDLE;
                end
            end
            S_TAKE: begin
                if (i_status.out_free) begin
                    o_cmd   = C_TAKE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ design/tile_slot_cache_controller_unit.sv @@
// top level of the tile slot cache controller
// Manages 64 cache slots with a replacement queue and a parallel tag compare.
// After reset the queue memory is filled with the slot numbers before the
// first request is taken. A request is taken only while the block is idle;
// for a lookup, ready, take or refusal on an empty queue its result is
// loaded into the output register from the state after the dispatch state.
// An allocation drops each busy slot it pops and pops the next while the
// queue is not empty; when the granted slot was occupied, its old tag is
// first read from the tag memory and run through the compare bank. A result is
// loaded only once the previous one has been taken, so a stalled output holds
// the block; a finished result waits in the output register while the next
// request is accepted.
module tile_slot_cache_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // resource_id, tile_id, slot_index, zero pad
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // ok, slot_out, evicted, load_count
);
    import tsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    tsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tsc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_kind   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule
